>>> src/dctl_pkg.sv
// shared types, codes, constants and arctangent table of the tilt and load monitor
package dctl_pkg;

  localparam int TIME_W     = 16;
  localparam int CMD_W      = 2;
  localparam int SAMPLE_W   = 16;
  localparam int ANGLE_W    = 11;
  localparam int MASS_W     = 12;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;
  localparam int DUTY_W     = 18;
  localparam int MAG_W      = 17;
  localparam int PROD_W     = 22;
  localparam int TENTHS_W   = 10;
  localparam int CORDIC_W   = 40;
  localparam int Z_W        = 29;
  localparam int TBL_W      = 25;
  localparam int TBL_IDX_W  = 5;

  localparam logic [CMD_W-1:0] CMD_X_EDGE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_Y_EDGE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVAL   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MIN = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MAX = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASS_MIN  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASS_MAX  = 4'd3;

  localparam logic [ANGLE_W-1:0] ANGLE_MIN_RST = 11'd100;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX_RST = 11'd1700;
  localparam logic [MASS_W-1:0]  MASS_MIN_RST  = 12'd0;
  localparam logic [MASS_W-1:0]  MASS_MAX_RST  = 12'd3600;

  localparam logic [ANGLE_W-1:0] ANGLE_RIGHT = 11'd900;
  localparam logic [ANGLE_W-1:0] ANGLE_FLAT  = 11'd1800;
  localparam logic [ANGLE_W-1:0] ANGLE_ZERO  = 11'd0;

  localparam logic [PROD_W-1:0] LOAD_HI_KNEE = 22'd1300000;
  localparam logic [PROD_W-1:0] LOAD_LO_KNEE = 22'd1100000;
  localparam logic [PROD_W-1:0] LOAD_HI_COMP = 22'd100000;
  localparam logic [PROD_W-1:0] LOAD_LO_COMP = 22'd60000;
  localparam logic [PROD_W-1:0] LOAD_ROUND   = 22'd500;
  // ceil(2^32 / 1000), exact for all products below 2^22
  localparam logic [22:0]       RECIP_1000   = 23'd4294968;

  localparam logic [25:0] Z_LIMIT = 26'd58982400;
  localparam logic [25:0] Z_HALF  = 26'd32768;

  typedef struct packed {
    logic [TIME_W-1:0] high;
    logic [TIME_W-1:0] period;
  } chan_meas_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
  } cordic_req_t;

  typedef struct packed {
    logic                busy;
    logic [TENTHS_W-1:0] tenths;
  } cordic_sts_t;

  // atan(2^-i) in units of 2^-16 tenth of a degree
  function automatic logic [TBL_W-1:0] atan_entry(input logic [TBL_IDX_W-1:0] idx);
    logic [TBL_W-1:0] v;
    case (idx)
      5'd0:    v = 25'd29491200;
      5'd1:    v = 25'd17409672;
      5'd2:    v = 25'd9198793;
      5'd3:    v = 25'd4669451;
      5'd4:    v = 25'd2343786;
      5'd5:    v = 25'd1173036;
      5'd6:    v = 25'd586661;
      5'd7:    v = 25'd293348;
      5'd8:    v = 25'd146676;
      5'd9:    v = 25'd73339;
      5'd10:   v = 25'd36669;
      5'd11:   v = 25'd18335;
      5'd12:   v = 25'd9167;
      5'd13:   v = 25'd4584;
      5'd14:   v = 25'd2292;
      5'd15:   v = 25'd1146;
      5'd16:   v = 25'd573;
      5'd17:   v = 25'd286;
      5'd18:   v = 25'd143;
      5'd19:   v = 25'd72;
      5'd20:   v = 25'd36;
      5'd21:   v = 25'd18;
      5'd22:   v = 25'd9;
      5'd23:   v = 25'd4;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

endpackage

>>> src/dctl_in_if.sv
// input channel: edge and evaluate beats
interface dctl_in_if;
  logic                           valid;
  logic                           ready;
  logic [dctl_pkg::CMD_W-1:0]     command;
  logic [dctl_pkg::TIME_W-1:0]    timestamp;
  logic [dctl_pkg::SAMPLE_W-1:0]  adc_sample;

  modport source (output valid, command, timestamp, adc_sample, input ready);
  modport sink   (input valid, command, timestamp, adc_sample, output ready);
endinterface

>>> src/dctl_out_if.sv
// result channel: one beat per evaluate
interface dctl_out_if;
  logic                          valid;
  logic                          ready;
  logic [dctl_pkg::ANGLE_W-1:0]  angle_tenths;
  logic                          angle_valid;
  logic                          angle_safe;
  logic [dctl_pkg::MASS_W-1:0]   mass_tenths;
  logic                          mass_safe;
  logic [dctl_pkg::TIME_W-1:0]   x_high_time;
  logic [dctl_pkg::TIME_W-1:0]   y_high_time;

  modport source (output valid, angle_tenths, angle_valid, angle_safe, mass_tenths,
                  mass_safe, x_high_time, y_high_time, input ready);
  modport sink   (input valid, angle_tenths, angle_valid, angle_safe, mass_tenths,
                  mass_safe, x_high_time, y_high_time, output ready);
endinterface

>>> src/dctl_cfg_if.sv
// configuration write channel
interface dctl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dctl_pkg::CFG_IDX_W-1:0]   index;
  logic [dctl_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/duty_cycle_tilt_and_load_monitor_top.sv
// top level of the duty-cycle tilt and load monitor: sequencer, mass path, windows
//
//  channel  dir  beat                                         ready
//  in_ch    in   command, timestamp, adc_sample                while idle
//  out_ch   out  angle, mass, window flags, x and y high time  from sink
//  cfg_ch   in   index, data                                   always
//
// an edge beat is taken in the idle state; an evaluate beat steps through prep, mass, wait
// and output, the wait step holding while the arctangent unit does one micro-rotation per
// cycle, or passing at once when the x duty offset is zero and the unit is skipped
// the result sits in an output register, so a new beat is taken while it waits
// a stalled result holds the sequencer in its last step until the slot frees
// synchronous active-low reset restores control and channel state, no clearing pass
module duty_cycle_tilt_and_load_monitor_top #(
  parameter int ANGLE_ITERATIONS = 16
) (
  input logic      clk,
  input logic      rst_n,
  dctl_in_if.sink    in_ch,
  dctl_out_if.source out_ch,
  dctl_cfg_if.sink   cfg_ch
);

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_MASS, S_WAIT, S_OUT} state_t;

  state_t                              state_r;
  logic [dctl_pkg::ANGLE_W-1:0]        angle_min_r, angle_max_r;
  logic [dctl_pkg::MASS_W-1:0]         mass_min_r, mass_max_r;
  logic [dctl_pkg::SAMPLE_W-1:0]       sample_r;
  logic signed [dctl_pkg::DUTY_W-1:0]  n_r, d_r, n_now, d_now, n_neg, d_neg;
  logic [dctl_pkg::PROD_W-1:0]         p_raw, p_adj, p_r, p_round;
  logic [44:0]                         mass_prod;
  logic [dctl_pkg::MASS_W-1:0]         mass_r;
  logic [dctl_pkg::ANGLE_W-1:0]        angle;
  logic                                valid_ang;
  logic                                load_out;
  logic                                out_valid_r;
  logic [dctl_pkg::ANGLE_W-1:0]        out_angle_r;
  logic                                out_avalid_r, out_asafe_r, out_msafe_r;
  logic [dctl_pkg::MASS_W-1:0]         out_mass_r;
  logic [dctl_pkg::TIME_W-1:0]         out_xh_r, out_yh_r;
  logic                                in_acc;
  dctl_pkg::chan_meas_t                x_meas, y_meas;
  dctl_pkg::cordic_req_t               cord_req;
  dctl_pkg::cordic_sts_t               cord_sts;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  dctl_edge_chan u_x_chan (
    .clk     (clk),
    .rst_n   (rst_n),
    .edge_en (in_acc && (in_ch.command == dctl_pkg::CMD_X_EDGE)),
    .ts      (in_ch.timestamp),
    .meas    (x_meas)
  );

  dctl_edge_chan u_y_chan (
    .clk     (clk),
    .rst_n   (rst_n),
    .edge_en (in_acc && (in_ch.command == dctl_pkg::CMD_Y_EDGE)),
    .ts      (in_ch.timestamp),
    .meas    (y_meas)
  );

  assign n_now = $signed({1'b0, y_meas.high, 1'b0}) - $signed({2'b0, y_meas.period});
  assign d_now = $signed({1'b0, x_meas.high, 1'b0}) - $signed({2'b0, x_meas.period});
  assign n_neg = -n_r;
  assign d_neg = -d_r;

  assign cord_req.start = (state_r == S_PREP) && (d_r != 0);
  assign cord_req.ax    = d_r[dctl_pkg::DUTY_W-1] ? d_neg[dctl_pkg::MAG_W-1:0]
                                                  : d_r[dctl_pkg::MAG_W-1:0];
  assign cord_req.ay    = n_r[dctl_pkg::DUTY_W-1] ? n_neg[dctl_pkg::MAG_W-1:0]
                                                  : n_r[dctl_pkg::MAG_W-1:0];

  dctl_cordic #(.ITER(ANGLE_ITERATIONS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cord_req),
    .sts   (cord_sts)
  );

  // load: sample * 35 with knee compensation, then rounded divide by 1000
  always_comb begin
    p_raw = {1'b0, sample_r, 5'b0} + {5'b0, sample_r, 1'b0} + {6'b0, sample_r};
    if (p_raw > dctl_pkg::LOAD_HI_KNEE) begin
      p_adj = p_raw - dctl_pkg::LOAD_HI_COMP;
    end else if (p_raw > dctl_pkg::LOAD_LO_KNEE) begin
      p_adj = p_raw - dctl_pkg::LOAD_LO_COMP;
    end else begin
      p_adj = p_raw;
    end
  end

  assign p_round   = p_r + dctl_pkg::LOAD_ROUND;
  assign mass_prod = p_round * dctl_pkg::RECIP_1000;

  always_comb begin
    valid_ang = 1'b1;
    angle     = dctl_pkg::ANGLE_ZERO;
    if (d_r == 0) begin
      if (n_r > 0) begin
        angle = dctl_pkg::ANGLE_ZERO;
      end else if (n_r < 0) begin
        angle = dctl_pkg::ANGLE_FLAT;
      end else begin
        valid_ang = 1'b0;
      end
    end else if (n_r[dctl_pkg::DUTY_W-1] != d_r[dctl_pkg::DUTY_W-1]) begin
      angle = dctl_pkg::ANGLE_RIGHT + {1'b0, cord_sts.tenths};
    end else begin
      angle = dctl_pkg::ANGLE_RIGHT - {1'b0, cord_sts.tenths};
    end
  end

  assign load_out = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_min_r <= dctl_pkg::ANGLE_MIN_RST;
      angle_max_r <= dctl_pkg::ANGLE_MAX_RST;
      mass_min_r  <= dctl_pkg::MASS_MIN_RST;
      mass_max_r  <= dctl_pkg::MASS_MAX_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        dctl_pkg::REG_ANGLE_MIN: angle_min_r <= cfg_ch.data[dctl_pkg::ANGLE_W-1:0];
        dctl_pkg::REG_ANGLE_MAX: angle_max_r <= cfg_ch.data[dctl_pkg::ANGLE_W-1:0];
        dctl_pkg::REG_MASS_MIN:  mass_min_r  <= cfg_ch.data;
        dctl_pkg::REG_MASS_MAX:  mass_max_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !load_out) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_ch.command == dctl_pkg::CMD_EVAL)) begin
            sample_r <= in_ch.adc_sample;
            n_r      <= n_now;
            d_r      <= d_now;
            state_r  <= S_PREP;
          end
        end
        S_PREP: begin
          p_r     <= p_adj;
          state_r <= S_MASS;
        end
        S_MASS: begin
          mass_r  <= mass_prod[43:32];
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (!cord_sts.busy) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (load_out) begin
            out_valid_r  <= 1'b1;
            out_angle_r  <= angle;
            out_avalid_r <= valid_ang;
            out_asafe_r  <= valid_ang && (angle >= angle_min_r) && (angle <= angle_max_r);
            out_mass_r   <= mass_r;
            out_msafe_r  <= (mass_r >= mass_min_r) && (mass_r <= mass_max_r);
            out_xh_r     <= x_meas.high;
            out_yh_r     <= y_meas.high;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.angle_tenths = out_angle_r;
  assign out_ch.angle_valid  = out_avalid_r;
  assign out_ch.angle_safe   = out_asafe_r;
  assign out_ch.mass_tenths  = out_mass_r;
  assign out_ch.mass_safe    = out_msafe_r;
  assign out_ch.x_high_time  = out_xh_r;
  assign out_ch.y_high_time  = out_yh_r;

`ifndef NO_ASSERTIONS
  a_cordic_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !cord_sts.busy)
    else $error("arctangent unit busy while block is idle");

  a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.command == dctl_pkg::CMD_EVAL)) |=> (state_r == S_PREP))
    else $error("evaluate beat did not start the sequencer");

  a_safe_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_asafe_r) |-> out_avalid_r)
    else $error("angle flagged safe without a valid angle");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_avalid_r) |-> (out_angle_r == dctl_pkg::ANGLE_ZERO))
    else $error("invalid angle is not zero");
`endif

endmodule

>>> src/dctl_edge_chan.sv
// one duty-cycle channel: rise time, period and high time from edge beats
module dctl_edge_chan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        edge_en,
  input  logic [dctl_pkg::TIME_W-1:0] ts,
  output dctl_pkg::chan_meas_t        meas
);

  logic                        phase_r;
  logic [dctl_pkg::TIME_W-1:0] rise_r;
  logic [dctl_pkg::TIME_W-1:0] period_r;
  logic [dctl_pkg::TIME_W-1:0] high_r;
  logic [dctl_pkg::TIME_W-1:0] delta;

  assign delta = ts - rise_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= 1'b0;
      rise_r   <= '0;
      period_r <= dctl_pkg::TIME_W'(1);
      high_r   <= '0;
    end else if (edge_en) begin
      phase_r <= ~phase_r;
      if (!phase_r) begin
        period_r <= delta;
        rise_r   <= ts;
      end else begin
        high_r <= delta;
      end
    end
  end

  assign meas.high   = high_r;
  assign meas.period = period_r;

endmodule

>>> src/dctl_cordic.sv
// iterative vectoring arctangent, one micro-rotation per cycle
module dctl_cordic #(
  parameter int ITER = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dctl_pkg::cordic_req_t req,
  output dctl_pkg::cordic_sts_t sts
);

  localparam int CNT_W = $clog2(ITER + 1);

  logic                                  busy_r;
  logic [CNT_W-1:0]                      cnt_r;
  logic signed [dctl_pkg::CORDIC_W-1:0]  x_r, y_r;
  logic signed [dctl_pkg::CORDIC_W-1:0]  x_nxt, y_nxt, xs, ys;
  logic signed [dctl_pkg::Z_W-1:0]       z_r, z_nxt, step;
  logic [dctl_pkg::TENTHS_W-1:0]         tenths_r;
  logic [25:0]                           z_clip, z_round;
  logic                                  last;

  assign xs   = x_r >>> cnt_r;
  assign ys   = y_r >>> cnt_r;
  assign step = $signed({4'b0, dctl_pkg::atan_entry(dctl_pkg::TBL_IDX_W'(cnt_r))});
  assign last = (cnt_r == CNT_W'(ITER - 1));

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (y_r > 0) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + step;
    end else if (y_r < 0) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - step;
    end
  end

  always_comb begin
    if (z_nxt < 0) begin
      z_clip = '0;
    end else if (z_nxt > $signed({3'b0, dctl_pkg::Z_LIMIT})) begin
      z_clip = dctl_pkg::Z_LIMIT;
    end else begin
      z_clip = z_nxt[25:0];
    end
    z_round = z_clip + dctl_pkg::Z_HALF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      x_r    <= $signed({3'b0, req.ax, 20'b0});
      y_r    <= $signed({3'b0, req.ay, 20'b0});
      z_r    <= '0;
    end else if (busy_r) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      cnt_r <= cnt_r + CNT_W'(1);
      if (last) begin
        busy_r   <= 1'b0;
        tenths_r <= z_round[25:16];
      end
    end
  end

  assign sts.busy   = busy_r;
  assign sts.tenths = tenths_r;

endmodule
